### hdl/rvft_pkg.sv
// ----------------------------------------------------------------------------
// rvft_pkg : shared types and constants of the range value frequency table
// Sizes, command codes, controller states and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package rvft_pkg;

    localparam int DEPTH       = 1024;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int COUNT_W     = 11;
    localparam int VALUE_IN_W  = 32;
    localparam int IDX_W       = 10;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1024);

    // register indexes on the configuration port
    localparam logic [PADDR_W-3:0] REG_ELEMENT_COUNT = '0;

    typedef enum logic {
        CMD_SET   = 1'b0,
        CMD_QUERY = 1'b1
    } t_command;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_WAIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic latch;      // capture the command beat, clear the count
        logic chk;        // capture the bounds verdict
        logic load_addr;  // scan pointer to range_low
        logic inc_addr;   // scan pointer up by one
        logic rd_en;      // memory read at scan pointer
        logic wr_en;      // memory write at index
    } t_ctrl_cmd;

    typedef struct packed {
        logic bad;
        logic is_query;
        logic at_high;
    } t_dp_status;

endpackage

### hdl/rvft_ram.sv
// ----------------------------------------------------------------------------
// rvft_ram : generic single-port RAM
// One access a cycle, write or read; read data registered.
// ----------------------------------------------------------------------------
module rvft_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/rvft_ctrl.sv
// ----------------------------------------------------------------------------
// rvft_ctrl : command sequencer
// Accept, bounds check, write or scan the range, then strobe the result.
// ----------------------------------------------------------------------------
module rvft_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  rvft_pkg::t_dp_status  i_status,
    output rvft_pkg::t_ctrl_cmd   o_cmd,
    output logic                  o_busy,
    output logic                  o_valid
);
    import rvft_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (!i_status.bad && i_status.is_query) n_state = ST_SCAN;
                else                                     n_state = ST_DONE;
            end
            ST_SCAN: begin
                if (i_status.at_high) n_state = ST_WAIT;
            end
            ST_WAIT:  n_state = ST_DONE;
            ST_DONE:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_busy  = 1'b1;
        o_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_busy      = 1'b0;
                o_cmd.latch = i_start;
            end
            ST_CHECK: begin
                o_cmd.chk       = 1'b1;
                o_cmd.load_addr = !i_status.bad && i_status.is_query;
                o_cmd.wr_en     = !i_status.bad && !i_status.is_query;
            end
            ST_SCAN: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.inc_addr = !i_status.at_high;
            end
            ST_WAIT: ;
            ST_DONE: begin
                o_valid = 1'b1;
            end
            default: ;
        endcase
    end

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.rd_en && o_cmd.wr_en))
        else $error("memory read and write in one cycle");

    a_scan_then_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && i_status.at_high) |=> (r_state == ST_WAIT))
        else $error("scan did not finish at range_high");

    a_bad_skips_mem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHECK && i_status.bad) |-> !o_cmd.wr_en && !o_cmd.load_addr)
        else $error("rejected command touched the memory");

endmodule

### hdl/rvft_dp.sv
// ----------------------------------------------------------------------------
// rvft_dp : datapath of the range value frequency table
// Operand registers, bounds check, scan pointer, value memory and match count.
// ----------------------------------------------------------------------------
module rvft_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  rvft_pkg::t_ctrl_cmd              i_cmd,
    input  logic [rvft_pkg::COUNT_W-1:0]     i_element_count,
    input  logic                             i_command,
    input  logic [rvft_pkg::IDX_W-1:0]       i_index,
    input  logic [rvft_pkg::VALUE_IN_W-1:0]  i_value,
    input  logic [rvft_pkg::IDX_W-1:0]       i_range_low,
    input  logic [rvft_pkg::IDX_W-1:0]       i_range_high,
    output rvft_pkg::t_dp_status             o_status,
    output logic [rvft_pkg::COUNT_W-1:0]     o_match_count,
    output logic                             o_bad_request
);
    import rvft_pkg::*;

    localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(DEPTH);

    t_command               r_cmd;
    logic [IDX_W-1:0]       r_index;
    logic [VALUE_WIDTH-1:0] r_value;
    logic [IDX_W-1:0]       r_low;
    logic [IDX_W-1:0]       r_high;
    logic [ADDR_W-1:0]      r_addr;
    logic [COUNT_W-1:0]     r_count;
    logic                   r_bad;
    logic                   r_pend;

    logic [COUNT_W-1:0]     eff_count;
    logic                   bad;
    logic [ADDR_W-1:0]      mem_addr;
    logic [VALUE_WIDTH-1:0] rdata;

    // positions in use, saturated at the memory depth
    assign eff_count = (i_element_count > DEPTH_C) ? DEPTH_C : i_element_count;

    always_comb begin
        if (r_cmd == CMD_SET) begin
            bad = {1'b0, r_index} >= eff_count;
        end else begin
            bad = (r_low > r_high) || ({1'b0, r_high} >= eff_count);
        end
    end

    assign o_status.bad      = bad;
    assign o_status.is_query = (r_cmd == CMD_QUERY);
    assign o_status.at_high  = (r_addr == ADDR_W'(r_high));

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_cmd   <= t_command'(i_command);
            r_index <= i_index;
            r_value <= i_value[VALUE_WIDTH-1:0];
            r_low   <= i_range_low;
            r_high  <= i_range_high;
        end
        if (i_cmd.load_addr)     r_addr <= ADDR_W'(r_low);
        else if (i_cmd.inc_addr) r_addr <= r_addr + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 1'b0;
            r_bad   <= 1'b0;
            r_count <= '0;
        end else begin
            r_pend <= i_cmd.rd_en;
            if (i_cmd.chk) r_bad <= bad;
            if (i_cmd.latch) begin
                r_count <= '0;
            end else if (r_pend && (rdata == r_value) && (r_count != COUNT_MAX)) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    assign mem_addr = i_cmd.wr_en ? ADDR_W'(r_index) : r_addr;

    rvft_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_re    (i_cmd.rd_en),
        .i_addr  (mem_addr),
        .i_wdata (r_value),
        .o_rdata (rdata)
    );

    assign o_match_count = r_bad ? '0 : r_count;
    assign o_bad_request = r_bad;

endmodule

### hdl/range_value_frequency_table_core.sv
// ----------------------------------------------------------------------------
// range_value_frequency_table_core : point-set / range-count value table
// Holds 1024 values of 32 bits; sets one position or counts matches in a range.
// ----------------------------------------------------------------------------
// Usage
//   Command channel: drive command, index, value, range_low, range_high with
//   start; the beat is taken on the edge where start is high and busy low.
//   Result channel: o_valid strobes for one cycle with o_match_count and
//   o_bad_request. The receiver cannot stall, so it must take the beat then.
//   Configuration: APB-style, element_count at byte address 0, pready tied
//   high, reads return the register. Write it only while busy is low.
// Sequence
//   A set, or any rejected command, is bounds checked, written if good,
//   and then returned. A query is checked and then scans lo..hi through the
//   single port of the value memory: one position is read per cycle, and
//   the read data is registered before it is compared.
//   Commands are handled one at a time; busy stays high until the result.
//   busy drops the cycle after the result, and the next beat can be taken
//   from then on.
// Reset
//   Synchronous, active low. The sequencer returns to idle and element_count
//   goes to 1024. The value memory is not cleared: a position must be set
//   before any query covers it.
// ----------------------------------------------------------------------------
module range_value_frequency_table_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // command channel
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_command,
    input  logic [rvft_pkg::IDX_W-1:0]       i_index,
    input  logic [rvft_pkg::VALUE_IN_W-1:0]  i_value,
    input  logic [rvft_pkg::IDX_W-1:0]       i_range_low,
    input  logic [rvft_pkg::IDX_W-1:0]       i_range_high,
    // result channel
    output logic                             o_valid,
    output logic [rvft_pkg::COUNT_W-1:0]     o_match_count,
    output logic                             o_bad_request,
    // configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rvft_pkg::PADDR_W-1:0]     paddr,
    input  logic [rvft_pkg::PDATA_W-1:0]     pwdata,
    output logic [rvft_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready
);
    import rvft_pkg::*;

    t_ctrl_cmd          ctrl_cmd;
    t_dp_status         dp_status;
    logic [COUNT_W-1:0] r_element_count;
    logic               cfg_wr;
    logic               reg_sel;

    // ---- configuration register -------------------------------------------
    // Register index is the byte address over four; only index zero exists,
    // other addresses write nothing and read as zero.
    assign pready  = 1'b1;
    assign reg_sel = (paddr[PADDR_W-1:2] == REG_ELEMENT_COUNT);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_element_count <= COUNT_RESET;
        end else if (cfg_wr && reg_sel) begin
            r_element_count <= pwdata[COUNT_W-1:0];
        end
    end

    assign prdata = reg_sel ? {{(PDATA_W-COUNT_W){1'b0}}, r_element_count} : '0;

    // ---- sequencer ----------------------------------------------------------
    rvft_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (dp_status),
        .o_cmd    (ctrl_cmd),
        .o_busy   (busy),
        .o_valid  (o_valid)
    );

    // ---- datapath: operands, bounds, memory, match counter ---------------
    rvft_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (ctrl_cmd),
        .i_element_count (r_element_count),
        .i_command       (i_command),
        .i_index         (i_index),
        .i_value         (i_value),
        .i_range_low     (i_range_low),
        .i_range_high    (i_range_high),
        .o_status        (dp_status),
        .o_match_count   (o_match_count),
        .o_bad_request   (o_bad_request)
    );

    // ---- checks ---------------------------------------------------------------
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bad_request) |-> (o_match_count == '0))
        else $error("rejected command with non-zero count");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

endmodule

### verif/range_value_frequency_table_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// range_value_frequency_table_core_tb : self-checking bench for the value table
// Drives set and range-count commands through the start/busy channel and
// writes element_count over the APB port. A scoreboard class keeps its own
// copy of the table and predicts each result beat. Stimulus runs in three
// parts: a directed part, a fill of the low positions, and then random phases
// under several element_count settings.
// ----------------------------------------------------------------------------
module range_value_frequency_table_core_tb;
    import rvft_pkg::*;

    localparam int unsigned STALL_LIMIT  = 5000;   // well above the longest query
    localparam int unsigned RANDOM_ITEMS = 320;
    localparam int unsigned PHASES       = 8;
    localparam int unsigned FILL_SPAN    = 256;    // positions written before random counts
    localparam int unsigned UNMAPPED_REG = 1;      // register index with nothing behind it
    localparam logic [PADDR_W-1:0] COUNT_ADDR    = PADDR_W'(int'(REG_ELEMENT_COUNT) * 4);
    localparam logic [PADDR_W-1:0] UNMAPPED_ADDR = PADDR_W'(UNMAPPED_REG * 4);

    typedef struct {
        logic [COUNT_W-1:0] match_count;
        logic               bad_request;
    } t_table_result;

    // ------------------------------------------------------------------------
    // Scoreboard: private copy of the table and of element_count, plus the
    // queue of result beats still owed by the block.
    // ------------------------------------------------------------------------
    class frequency_scoreboard;
        logic [VALUE_WIDTH-1:0] cells [DEPTH];
        logic [COUNT_W-1:0]     element_count;
        t_table_result          owed_results [$];

        function new();
            element_count = COUNT_RESET;
        endfunction

        function void write_register(int unsigned reg_idx, logic [PDATA_W-1:0] data);
            if (reg_idx == int'(REG_ELEMENT_COUNT))
                element_count = data[COUNT_W-1:0];
        endfunction

        // element_count saturated at the table depth
        function int unsigned positions_in_use();
            return (element_count > DEPTH) ? DEPTH : int'(element_count);
        endfunction

        function void note_command(t_command cmd, logic [IDX_W-1:0] idx,
                                   logic [VALUE_IN_W-1:0] val,
                                   logic [IDX_W-1:0] lo, logic [IDX_W-1:0] hi);
            t_table_result res;
            int unsigned   n;
            int unsigned   hits;
            n               = positions_in_use();
            hits            = 0;
            res.match_count = '0;
            res.bad_request = 1'b0;
            if (cmd == CMD_SET) begin
                if (idx >= n)
                    res.bad_request = 1'b1;
                else
                    cells[idx] = val[VALUE_WIDTH-1:0];
            end else if (lo > hi || hi >= n) begin
                res.bad_request = 1'b1;
            end else begin
                for (int unsigned p = lo; p <= hi; p++)
                    if (cells[p] == val[VALUE_WIDTH-1:0])
                        hits++;
                res.match_count = (hits > COUNT_MAX) ? COUNT_MAX : hits[COUNT_W-1:0];
            end
            owed_results.push_back(res);
        endfunction

        function bit check_result(logic [COUNT_W-1:0] count, logic bad, output string why);
            t_table_result want;
            why = "";
            if (owed_results.size() == 0) begin
                why = $sformatf("result beat count=%0d bad=%0b with nothing owed", count, bad);
                return 1'b0;
            end
            want = owed_results.pop_front();
            if (bad !== want.bad_request)
                why = $sformatf("bad_request %0b, want %0b; ", bad, want.bad_request);
            if (count !== want.match_count)
                why = {why, $sformatf("match_count %0d, want %0d", count, want.match_count)};
            return why == "";
        endfunction

        function int unsigned outstanding();
            return owed_results.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic                   i_command;
    logic [IDX_W-1:0]       i_index;
    logic [VALUE_IN_W-1:0]  i_value;
    logic [IDX_W-1:0]       i_range_low;
    logic [IDX_W-1:0]       i_range_high;
    logic                   o_valid;
    logic [COUNT_W-1:0]     o_match_count;
    logic                   o_bad_request;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_W-1:0]     paddr;
    logic [PDATA_W-1:0]     pwdata;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    frequency_scoreboard    score;
    int unsigned            error_count;
    logic [VALUE_IN_W-1:0]  value_pool [4];

    range_value_frequency_table_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_command     (i_command),
        .i_index       (i_index),
        .i_value       (i_value),
        .i_range_low   (i_range_low),
        .i_range_high  (i_range_high),
        .o_valid       (o_valid),
        .o_match_count (o_match_count),
        .o_bad_request (o_bad_request),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 2 ns clock
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Result side: the block cannot be held off, so every strobe is a beat.
    always @(posedge i_clk) begin
        string why;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (!score.check_result(o_match_count, o_bad_request, why))
                report_mismatch(why);
        end
    end

    // ------------------------------------------------------------------------
    // Command channel
    // ------------------------------------------------------------------------
    // Holds the beat until the edge with busy low, then notes it. start stays
    // high on return so a following beat is driven without start dropping.
    task automatic issue(input t_command cmd, input logic [IDX_W-1:0] idx,
                         input logic [VALUE_IN_W-1:0] val,
                         input logic [IDX_W-1:0] lo, input logic [IDX_W-1:0] hi);
        @(negedge i_clk);
        start        <= 1'b1;
        i_command    <= cmd;
        i_index      <= idx;
        i_value      <= val;
        i_range_low  <= lo;
        i_range_high <= hi;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        score.note_command(cmd, idx, val, lo, hi);
    endtask

    task automatic pause_sender(input int unsigned cycles);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    task automatic maybe_idle(input bit allowed);
        if (allowed && $urandom_range(3) == 0)
            pause_sender($urandom_range(10, 1));
    endtask

    // Sender holds off until every owed beat has come back.
    task automatic wait_quiet();
        pause_sender(1);
        while (score.outstanding() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // APB side
    // ------------------------------------------------------------------------
    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (pready !== 1'b1);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(input logic [PADDR_W-1:0] addr, output logic [PDATA_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (pready !== 1'b1);
        data = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_count_register();
        logic [PDATA_W-1:0] got;
        apb_read(COUNT_ADDR, got);
        if (got !== PDATA_W'(score.element_count))
            report_mismatch($sformatf("element_count reads %0d, want %0d",
                                      got, score.element_count));
    endtask

    // Upper pwdata bits carry junk; only the low 11 bits are the register.
    task automatic set_element_count(input logic [COUNT_W-1:0] count);
        logic [PDATA_W-1:0] data;
        wait_quiet();
        data = ($urandom() & ~PDATA_W'(COUNT_MAX)) | PDATA_W'(count);
        apb_write(COUNT_ADDR, data);
        score.write_register(REG_ELEMENT_COUNT, data);
        check_count_register();
    endtask

    // ------------------------------------------------------------------------
    // Random stimulus
    // ------------------------------------------------------------------------
    // A small pool of values keeps matches frequent.
    function automatic logic [VALUE_IN_W-1:0] pick_value();
        if ($urandom_range(9) < 7)
            return value_pool[$urandom_range(3)];
        return $urandom();
    endfunction

    task automatic random_command();
        int unsigned           n;
        int unsigned           r;
        int unsigned           len;
        int unsigned           span;
        logic [IDX_W-1:0]      idx;
        logic [IDX_W-1:0]      lo;
        logic [IDX_W-1:0]      hi;
        logic [VALUE_IN_W-1:0] val;
        n   = score.positions_in_use();
        r   = $urandom_range(99);
        idx = IDX_W'($urandom());
        lo  = IDX_W'($urandom());
        hi  = IDX_W'($urandom());
        val = pick_value();
        if (r < 40) begin
            // mostly in bounds, some sets past the end
            if (n > 0 && r < 36)
                idx = IDX_W'($urandom_range(n - 1));
            issue(CMD_SET, idx, val, lo, hi);
        end else if (r < 90 && n > 0) begin
            // well-formed range inside the filled span, usually short
            span = (n < FILL_SPAN) ? n : FILL_SPAN;
            len  = ($urandom_range(39) == 0) ? $urandom_range(span, 1) : $urandom_range(16, 1);
            if (len > span)
                len = span;
            lo = IDX_W'($urandom_range(span - len));
            hi = IDX_W'(lo + len - 1);
            issue(CMD_QUERY, idx, val, lo, hi);
        end else begin
            // broken range: past the positions in use, or inverted
            if (n < DEPTH && r[0]) begin
                hi = IDX_W'($urandom_range(DEPTH - 1, n));
            end else begin
                lo = IDX_W'($urandom_range(DEPTH - 1, 1));
                hi = IDX_W'($urandom_range(lo - 1));
            end
            issue(CMD_QUERY, idx, val, lo, hi);
        end
    endtask

    // ------------------------------------------------------------------------
    // Watchdog: ends the run after a long stretch with no beat either way.
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((start === 1'b1 && busy === 1'b0) || o_valid === 1'b1)
                quiet = 0;
            else
                quiet++;
        end
        $display("range_value_frequency_table_core regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [COUNT_W-1:0] phase_counts [PHASES];
        logic [COUNT_W-1:0] mid_count;
        score        = new();
        error_count  = 0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_command    = CMD_SET;
        i_index      = '0;
        i_value      = '0;
        i_range_low  = '0;
        i_range_high = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        value_pool[0] = '0;
        value_pool[1] = '1;
        value_pool[2] = $urandom();
        value_pool[3] = $urandom();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset value of element_count
        check_count_register();

        // --- directed part, full table width ---
        issue(CMD_SET, 10'd0, 32'h0000_0000, '0, '0);
        issue(CMD_SET, 10'd1, 32'hFFFF_FFFF, '0, '0);
        issue(CMD_SET, 10'd1022, 32'h8000_0001, '0, '0);
        issue(CMD_SET, 10'd1023, 32'hFFFF_FFFF, '0, '0);
        issue(CMD_QUERY, '0, 32'h0000_0000, 10'd0, 10'd0);
        issue(CMD_QUERY, '0, 32'hFFFF_FFFF, 10'd0, 10'd1);
        issue(CMD_QUERY, '1, 32'hFFFF_FFFF, 10'd1022, 10'd1023);
        issue(CMD_QUERY, '0, 32'h8000_0001, 10'd1023, 10'd1023);
        // inverted ranges are rejected without reading the table
        issue(CMD_QUERY, '0, 32'h0000_0000, 10'd5, 10'd4);
        issue(CMD_QUERY, '0, 32'hFFFF_FFFF, 10'd1023, 10'd0);

        // single position in use
        set_element_count(11'd1);
        issue(CMD_SET, 10'd0, 32'h0000_0007, '0, '0);
        issue(CMD_SET, 10'd1, 32'h0000_0007, '0, '0);
        issue(CMD_SET, 10'd1023, 32'h0000_0007, '0, '0);
        issue(CMD_QUERY, '0, 32'h0000_0007, 10'd0, 10'd0);
        issue(CMD_QUERY, '0, 32'h0000_0007, 10'd0, 10'd1);

        // zero in use: every command is refused
        set_element_count(11'd0);
        issue(CMD_SET, 10'd0, 32'h1234_5678, '0, '0);
        issue(CMD_QUERY, '0, 32'h0000_0007, 10'd0, 10'd0);

        // count above the depth saturates
        set_element_count(COUNT_MAX);
        issue(CMD_QUERY, '0, 32'hFFFF_FFFF, 10'd1022, 10'd1023);
        issue(CMD_SET, 10'd1023, 32'h0000_0000, '0, '0);

        // a write to an unmapped register leaves element_count alone
        set_element_count(COUNT_RESET);
        apb_write(UNMAPPED_ADDR, $urandom());
        score.write_register(UNMAPPED_REG, '0);
        check_count_register();

        // --- fill the low span so any range inside it may be counted ---
        for (int unsigned p = 0; p < FILL_SPAN; p++) begin
            maybe_idle(1'b1);
            issue(CMD_SET, IDX_W'(p), pick_value(), IDX_W'($urandom()), IDX_W'($urandom()));
        end
        for (int unsigned v = 0; v < 4; v++)
            issue(CMD_QUERY, IDX_W'($urandom()), value_pool[v], 10'd0, IDX_W'(FILL_SPAN - 1));

        // --- random phases, one element_count setting each ---
        mid_count = COUNT_W'($urandom_range(1023, 3));
        phase_counts = '{COUNT_RESET, COUNT_MAX, 11'd1, 11'd0,
                         mid_count, 11'd2, 11'd1500, COUNT_RESET};
        for (int unsigned ph = 0; ph < PHASES; ph++) begin
            set_element_count(phase_counts[ph]);
            for (int unsigned k = 0; k < RANDOM_ITEMS / PHASES; k++) begin
                // last phase runs flat out
                maybe_idle(ph != PHASES - 1);
                if (ph != PHASES - 1 && $urandom_range(39) == 0)
                    wait_quiet();
                random_command();
            end
        end

        // --- drain and close ---
        pause_sender(1);
        while (score.outstanding() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (score.outstanding() != 0)
            report_mismatch($sformatf("%0d result beats never arrived", score.outstanding()));
        if (error_count == 0)
            $display("range_value_frequency_table_core regression: pass");
        else
            $display("range_value_frequency_table_core regression: fail");
        $finish;
    end

endmodule
